// ===== design/knapsack_01_dp_solver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// knapsack solver assertion macros
// Concurrent check macros used by the sequencer module; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef KNAPSACK_01_DP_SOLVER_UNIT_MACROS_SVH
`define KNAPSACK_01_DP_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTH
`define KDP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("kdp: same-cycle check failed");
`define KDP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("kdp: next-cycle check failed");
`else
`define KDP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define KDP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/kdp_pkg.sv =====
// ----------------------------------------------------------------------------
// kdp_pkg
// Shared constants, types and helpers of the 0/1 knapsack solver.
// ----------------------------------------------------------------------------
package kdp_pkg;

	localparam int MAX_ITEMS_DEF    = 32;
	localparam int MAX_CAPACITY_DEF = 255;
	localparam int WEIGHT_W         = 8;
	localparam int ITEM_PROFIT_W    = 16;
	localparam int PROFIT_W         = 21;
	localparam int INDEX_W          = 5;
	localparam int CAPACITY_W       = 8;
	localparam int RES_LIMIT        = 32;
	localparam int CFG_DATA_W       = 32;
	localparam int CFG_ADDR_W       = 3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_DRAIN,
		ST_TR_BEST,
		ST_TR_LOAD,
		ST_TR_RD,
		ST_TR_CHK,
		ST_FLUSH
	} kdp_state_t;

	// register index as decoded from paddr[2]
	typedef enum logic {
		CFG_CAPACITY = 1'b0
	} cfg_reg_t;

	// memory port enables from the sequencer
	typedef struct packed {
		logic row_rd;
		logic row_we;
		logic keep_rd;
		logic keep_we;
		logic wt_rd;
		logic wt_we;
	} mem_ctrl_t;

	// status flags of the shared arithmetic unit
	typedef struct packed {
		logic ge;
		logic take;
	} alu_flags_t;

	// index width for a store of n entries, at least one bit
	function automatic int idx_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== design/kdp_alu.sv =====
// ----------------------------------------------------------------------------
// kdp_alu
// Shared arithmetic unit: weight subtract and compare, saturating profit add
// with strict compare against the current row entry.
// ----------------------------------------------------------------------------
module kdp_alu import kdp_pkg::*; #(
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
	localparam int CAP_W = idx_width(MAX_CAPACITY + 1),
	localparam int J_W   = (CAP_W > WEIGHT_W) ? CAP_W : WEIGHT_W
) (
	input  logic [CAP_W-1:0]         sub_x,
	input  logic [WEIGHT_W-1:0]      sub_w,
	input  logic [ITEM_PROFIT_W-1:0] add_profit,
	input  logic [PROFIT_W-1:0]      add_old_a,
	input  logic [PROFIT_W-1:0]      add_old_b,
	input  logic                     add_ge,
	output logic [CAP_W-1:0]         sub_diff,
	output logic [PROFIT_W-1:0]      add_new,
	output alu_flags_t               flags
);

	logic [J_W-1:0]        x_ext;
	logic [J_W-1:0]        w_ext;
	logic [J_W-1:0]        diff_full;
	logic [PROFIT_W:0]     sum_full;
	logic [PROFIT_W-1:0]   sum_sat;

	// subtract/compare and saturating add, both feeding the flags
	always_comb begin
		// capacity minus weight, shared by row addressing and trace-back
		x_ext     = J_W'(sub_x);
		w_ext     = J_W'(sub_w);
		diff_full = x_ext - w_ext;
		sub_diff  = diff_full[CAP_W-1:0];
		flags.ge  = (x_ext >= w_ext);
		// profit plus shifted entry, saturated, taken only if strictly better
		sum_full   = (PROFIT_W + 1)'(add_profit) + {1'b0, add_old_b};
		sum_sat    = sum_full[PROFIT_W] ? {PROFIT_W{1'b1}} : sum_full[PROFIT_W-1:0];
		flags.take = add_ge && (sum_sat > add_old_a);
		add_new    = flags.take ? sum_sat : add_old_a;
	end

endmodule

// ===== design/kdp_store.sv =====
// ----------------------------------------------------------------------------
// kdp_store
// Best-profit row, keep-bit table and stored weights, with registered reads.
// ----------------------------------------------------------------------------
module kdp_store import kdp_pkg::*; #(
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
	localparam int CAP_W = idx_width(MAX_CAPACITY + 1),
	localparam int IDX_W = idx_width(MAX_ITEMS),
	localparam int KA_W  = IDX_W + CAP_W
) (
	input  logic                  clk,
	input  mem_ctrl_t             ctrl,
	input  logic [CAP_W-1:0]      row_ra,
	input  logic [CAP_W-1:0]      row_rb,
	input  logic [CAP_W-1:0]      row_wa,
	input  logic [PROFIT_W-1:0]   row_wd,
	output logic [PROFIT_W-1:0]   row_rd_a,
	output logic [PROFIT_W-1:0]   row_rd_b,
	input  logic [KA_W-1:0]       keep_ra,
	input  logic [KA_W-1:0]       keep_wa,
	input  logic                  keep_wd,
	output logic                  keep_rd,
	input  logic [IDX_W-1:0]      wt_ra,
	input  logic [IDX_W-1:0]      wt_wa,
	input  logic [WEIGHT_W-1:0]   wt_wd,
	output logic [WEIGHT_W-1:0]   wt_rd
);

	logic [PROFIT_W-1:0] row_mem  [MAX_CAPACITY+1];
	logic                keep_mem [2**KA_W];
	logic [WEIGHT_W-1:0] wt_mem   [MAX_ITEMS];

	// row: one write port, two read ports
	always_ff @(posedge clk) begin
		if (ctrl.row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		if (ctrl.row_rd) begin
			row_rd_a <= row_mem[row_ra];
			row_rd_b <= row_mem[row_rb];
		end
	end

	// keep bits addressed by item and capacity
	always_ff @(posedge clk) begin
		if (ctrl.keep_we) begin
			keep_mem[keep_wa] <= keep_wd;
		end
		if (ctrl.keep_rd) begin
			keep_rd <= keep_mem[keep_ra];
		end
	end

	// per-item weights for trace-back
	always_ff @(posedge clk) begin
		if (ctrl.wt_we) begin
			wt_mem[wt_wa] <= wt_wd;
		end
		if (ctrl.wt_rd) begin
			wt_rd <= wt_mem[wt_ra];
		end
	end

endmodule

// ===== design/kdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kdp_ctrl
// Sequencer: row update sweep per item, trace-back over the keep bits and
// the result register.
// ----------------------------------------------------------------------------
`include "knapsack_01_dp_solver_unit_macros.svh"

module kdp_ctrl import kdp_pkg::*; #(
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
	localparam int CAP_W   = idx_width(MAX_CAPACITY + 1),
	localparam int IDX_W   = idx_width(MAX_ITEMS),
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1),
	localparam int KA_W    = IDX_W + CAP_W,
	localparam int CE_W    = (CAP_W > CAPACITY_W) ? CAP_W : CAPACITY_W,
	localparam int FOUND_W = $clog2(RES_LIMIT + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [WEIGHT_W-1:0]      in_weight,
	input  logic [ITEM_PROFIT_W-1:0] in_profit,
	input  logic                     in_last,
	input  logic [CAPACITY_W-1:0]    capacity,
	output mem_ctrl_t                mem_ctrl,
	output logic [CAP_W-1:0]         row_ra,
	output logic [CAP_W-1:0]         row_rb,
	output logic [CAP_W-1:0]         row_wa,
	output logic [PROFIT_W-1:0]      row_wd,
	input  logic [PROFIT_W-1:0]      row_rd_a,
	input  logic [PROFIT_W-1:0]      row_rd_b,
	output logic [KA_W-1:0]          keep_ra,
	output logic [KA_W-1:0]          keep_wa,
	output logic                     keep_wd,
	input  logic                     keep_rd,
	output logic [IDX_W-1:0]         wt_ra,
	output logic [IDX_W-1:0]         wt_wa,
	output logic [WEIGHT_W-1:0]      wt_wd,
	input  logic [WEIGHT_W-1:0]      wt_rd,
	output logic [CAP_W-1:0]         sub_x,
	output logic [WEIGHT_W-1:0]      sub_w,
	output logic [ITEM_PROFIT_W-1:0] add_profit,
	output logic [PROFIT_W-1:0]      add_old_a,
	output logic [PROFIT_W-1:0]      add_old_b,
	output logic                     add_ge,
	input  logic [CAP_W-1:0]         sub_diff,
	input  logic [PROFIT_W-1:0]      add_new,
	input  alu_flags_t               alu_flags,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [INDEX_W-1:0]       out_index,
	output logic                     out_chosen,
	output logic [PROFIT_W-1:0]      out_profit,
	output logic                     out_overflow,
	output logic                     out_last
);

	kdp_state_t state_q, state_d;

	logic [CNT_W-1:0]         count_q;
	logic                     dropped_q;
	logic                     last_q;
	logic [WEIGHT_W-1:0]      weight_q;
	logic [ITEM_PROFIT_W-1:0] profit_q;
	logic [CAP_W-1:0]         j_q;
	logic                     upd_valid_s1;
	logic [CAP_W-1:0]         upd_j_s1;
	logic                     upd_ge_s1;
	logic [CAP_W-1:0]         k_q;
	logic [CNT_W-1:0]         rem_q;
	logic [FOUND_W-1:0]       found_q;
	logic                     pend_q;
	logic [INDEX_W-1:0]       pend_idx_q;
	logic [PROFIT_W-1:0]      best_q;
	logic                     out_valid_q;
	logic [INDEX_W-1:0]       out_index_q;
	logic                     out_chosen_q;
	logic [PROFIT_W-1:0]      out_profit_q;
	logic                     out_overflow_q;
	logic                     out_last_q;

	logic                     in_fire;
	logic                     has_room;
	logic                     first;
	logic                     tr_done;
	logic                     out_free;
	logic                     proceed;
	logic                     load_chk;
	logic                     load_flush;
	logic [CE_W-1:0]          cap_ext;
	logic [CAP_W-1:0]         cap_eff;
	logic [CNT_W-1:0]         tr_idx;
	logic [INDEX_W+CNT_W-1:0] tr_idx_ext;
	logic [INDEX_W-1:0]       tr_idx5;

	// handshake and status terms
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		in_fire    = in_valid && in_ready;
		has_room   = (count_q < CNT_W'(MAX_ITEMS));
		first      = (count_q == '0);
		tr_done    = (rem_q == '0) || (found_q == FOUND_W'(RES_LIMIT));
		out_free   = !out_valid_q || out_ready;
		proceed    = !(keep_rd && pend_q) || out_free;
		cap_ext    = CE_W'(capacity);
		cap_eff    = (cap_ext > CE_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY)
			: cap_ext[CAP_W-1:0];
		tr_idx     = rem_q - 1'b1;
		tr_idx_ext = {{INDEX_W{1'b0}}, tr_idx};
		tr_idx5    = tr_idx_ext[INDEX_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (has_room) begin
						state_d = ST_UPD;
					end else if (in_last) begin
						state_d = ST_TR_BEST;
					end
				end
			end
			ST_UPD: begin
				if (j_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = last_q ? ST_TR_BEST : ST_IDLE;
			ST_TR_BEST: state_d = ST_TR_LOAD;
			ST_TR_LOAD: state_d = ST_TR_RD;
			ST_TR_RD:   state_d = tr_done ? ST_FLUSH : ST_TR_CHK;
			ST_TR_CHK: begin
				if (proceed) begin
					state_d = ST_TR_RD;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory enables and result loads
	always_comb begin
		mem_ctrl         = '0;
		mem_ctrl.row_we  = upd_valid_s1;
		mem_ctrl.keep_we = upd_valid_s1;
		load_chk         = 1'b0;
		load_flush       = 1'b0;
		unique case (state_q)
			ST_UPD:     mem_ctrl.row_rd = 1'b1;
			ST_DRAIN:   mem_ctrl.wt_we = 1'b1;
			ST_TR_BEST: mem_ctrl.row_rd = 1'b1;
			ST_TR_RD: begin
				mem_ctrl.keep_rd = !tr_done;
				mem_ctrl.wt_rd   = !tr_done;
			end
			ST_TR_CHK:  load_chk = proceed && keep_rd && pend_q;
			ST_FLUSH:   load_flush = out_free;
			default: ;
		endcase
	end

	// addresses and shared unit operands
	always_comb begin
		sub_x      = (state_q == ST_UPD) ? j_q : k_q;
		sub_w      = (state_q == ST_UPD) ? weight_q : wt_rd;
		row_ra     = (state_q == ST_TR_BEST) ? cap_eff : j_q;
		row_rb     = sub_diff;
		add_profit = profit_q;
		add_old_a  = first ? '0 : row_rd_a;
		add_old_b  = first ? '0 : row_rd_b;
		add_ge     = upd_ge_s1;
		row_wa     = upd_j_s1;
		row_wd     = add_new;
		keep_wa    = {count_q[IDX_W-1:0], upd_j_s1};
		keep_wd    = alu_flags.take;
		keep_ra    = {tr_idx[IDX_W-1:0], k_q};
		wt_ra      = tr_idx[IDX_W-1:0];
		wt_wa      = count_q[IDX_W-1:0];
		wt_wd      = weight_q;
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			upd_valid_s1 <= 1'b0;
			pend_q       <= 1'b0;
			found_q      <= '0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			upd_valid_s1 <= (state_q == ST_UPD);
			if (in_fire && !has_room) begin
				dropped_q <= 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_TR_LOAD) begin
				rem_q   <= count_q;
				found_q <= '0;
				pend_q  <= 1'b0;
			end
			if (state_q == ST_TR_CHK && proceed) begin
				rem_q <= rem_q - 1'b1;
				if (keep_rd) begin
					found_q <= found_q + 1'b1;
					pend_q  <= 1'b1;
				end
			end
			if (load_flush) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				pend_q    <= 1'b0;
			end
			// result register: a load wins over a take
			if (load_chk || load_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			weight_q <= in_weight;
			profit_q <= in_profit;
			last_q   <= in_last;
			j_q      <= CAP_W'(MAX_CAPACITY);
		end else if (state_q == ST_UPD && j_q != '0) begin
			j_q <= j_q - 1'b1;
		end
		upd_j_s1  <= j_q;
		upd_ge_s1 <= alu_flags.ge;
		if (state_q == ST_TR_BEST) begin
			k_q <= cap_eff;
		end
		if (state_q == ST_TR_LOAD) begin
			best_q <= row_rd_a;
		end
		if (state_q == ST_TR_CHK && proceed && keep_rd) begin
			k_q        <= sub_diff;
			pend_idx_q <= tr_idx5;
		end
		if (load_chk) begin
			out_index_q    <= pend_idx_q;
			out_chosen_q   <= 1'b1;
			out_profit_q   <= best_q;
			out_overflow_q <= dropped_q;
			out_last_q     <= 1'b0;
		end else if (load_flush) begin
			out_index_q    <= pend_q ? pend_idx_q : '0;
			out_chosen_q   <= pend_q;
			out_profit_q   <= best_q;
			out_overflow_q <= dropped_q;
			out_last_q     <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_index    = out_index_q;
	assign out_chosen   = out_chosen_q;
	assign out_profit   = out_profit_q;
	assign out_overflow = out_overflow_q;
	assign out_last     = out_last_q;

	// checks
	`KDP_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == ST_IDLE, !upd_valid_s1)
	`KDP_ASSERT_IMP(a_keep_fits, clk, arst_n, state_q == ST_TR_CHK && keep_rd, alu_flags.ge)
	`KDP_ASSERT_NXT(a_chk_push, clk, arst_n, load_chk, out_valid_q && !out_last_q)
	`KDP_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_ITEMS))

endmodule

// ===== design/knapsack_01_dp_solver_unit.sv =====
// ----------------------------------------------------------------------------
// knapsack_01_dp_solver_unit
// Streaming 0/1 knapsack solver: one best-profit row updated per item, keep
// bits per item and capacity, trace-back of the chosen items on the last one.
// ----------------------------------------------------------------------------
//  channel   direction  payload (low bit up)                     accept
//  s_*       in         tdata: weight[7:0] profit[23:8]; tlast    tvalid & tready
//  m_*       out        tdata: index[4:0] profit[25:5]; tuser:    tvalid & tready
//                       chosen[0] overflow[1]; tlast
//  apb       in         capacity at byte address 0                psel&penable&pwrite
//
//  a stored item sweeps the row through the shared add/compare unit, one
//  entry a cycle from MAX_CAPACITY down to 0, then passes a drain state;
//  a dropped item is only accepted; the last item adds a trace-back over the
//  stored items, one keep-bit read a step, plus output stalls
//  no clearing pass: the first item of a problem reads the row as zero
//  s_tready is low while an item is being worked on; results wait in one
//  output register that the next item does not block
// ----------------------------------------------------------------------------
module knapsack_01_dp_solver_unit import kdp_pkg::*; #(
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // weight[7:0], profit[23:8]
	input  logic                  s_tlast,   // last_item
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // chosen_index[4:0], max_profit[25:5]
	output logic [1:0]            m_tuser,   // chosen_valid[0], overflow[1]
	output logic                  m_tlast    // last_result
);

	localparam int CAP_W = idx_width(MAX_CAPACITY + 1);
	localparam int IDX_W = idx_width(MAX_ITEMS);
	localparam int KA_W  = IDX_W + CAP_W;

	logic [CAPACITY_W-1:0] capacity_q;
	logic                  cfg_write;

	mem_ctrl_t             mem_ctrl;
	logic [CAP_W-1:0]      row_ra, row_rb, row_wa;
	logic [PROFIT_W-1:0]   row_wd, row_rd_a, row_rd_b;
	logic [KA_W-1:0]       keep_ra, keep_wa;
	logic                  keep_wd, keep_rd;
	logic [IDX_W-1:0]      wt_ra, wt_wa;
	logic [WEIGHT_W-1:0]   wt_wd, wt_rd;

	logic [CAP_W-1:0]         sub_x, sub_diff;
	logic [WEIGHT_W-1:0]      sub_w;
	logic [ITEM_PROFIT_W-1:0] add_profit;
	logic [PROFIT_W-1:0]      add_old_a, add_old_b, add_new;
	logic                     add_ge;
	alu_flags_t               alu_flags;

	logic [INDEX_W-1:0]  out_index;
	logic                out_chosen;
	logic [PROFIT_W-1:0] out_profit;
	logic                out_overflow;

	// configuration register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_write) begin
			capacity_q <= pwdata[CAPACITY_W-1:0];
		end
	end

	assign prdata = (paddr[2] == CFG_CAPACITY) ? CFG_DATA_W'(capacity_q) : '0;

	// sequencer
	kdp_ctrl #(
		.MAX_ITEMS    (MAX_ITEMS),
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_weight    (s_tdata[7:0]),
		.in_profit    (s_tdata[23:8]),
		.in_last      (s_tlast),
		.capacity     (capacity_q),
		.mem_ctrl     (mem_ctrl),
		.row_ra       (row_ra),
		.row_rb       (row_rb),
		.row_wa       (row_wa),
		.row_wd       (row_wd),
		.row_rd_a     (row_rd_a),
		.row_rd_b     (row_rd_b),
		.keep_ra      (keep_ra),
		.keep_wa      (keep_wa),
		.keep_wd      (keep_wd),
		.keep_rd      (keep_rd),
		.wt_ra        (wt_ra),
		.wt_wa        (wt_wa),
		.wt_wd        (wt_wd),
		.wt_rd        (wt_rd),
		.sub_x        (sub_x),
		.sub_w        (sub_w),
		.add_profit   (add_profit),
		.add_old_a    (add_old_a),
		.add_old_b    (add_old_b),
		.add_ge       (add_ge),
		.sub_diff     (sub_diff),
		.add_new      (add_new),
		.alu_flags    (alu_flags),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_index    (out_index),
		.out_chosen   (out_chosen),
		.out_profit   (out_profit),
		.out_overflow (out_overflow),
		.out_last     (m_tlast)
	);

	// storage
	kdp_store #(
		.MAX_ITEMS    (MAX_ITEMS),
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_store (
		.clk      (clk),
		.ctrl     (mem_ctrl),
		.row_ra   (row_ra),
		.row_rb   (row_rb),
		.row_wa   (row_wa),
		.row_wd   (row_wd),
		.row_rd_a (row_rd_a),
		.row_rd_b (row_rd_b),
		.keep_ra  (keep_ra),
		.keep_wa  (keep_wa),
		.keep_wd  (keep_wd),
		.keep_rd  (keep_rd),
		.wt_ra    (wt_ra),
		.wt_wa    (wt_wa),
		.wt_wd    (wt_wd),
		.wt_rd    (wt_rd)
	);

	// shared arithmetic unit
	kdp_alu #(
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_alu (
		.sub_x      (sub_x),
		.sub_w      (sub_w),
		.add_profit (add_profit),
		.add_old_a  (add_old_a),
		.add_old_b  (add_old_b),
		.add_ge     (add_ge),
		.sub_diff   (sub_diff),
		.add_new    (add_new),
		.flags      (alu_flags)
	);

	// result packing
	assign m_tdata = {6'b0, out_profit, out_index};
	assign m_tuser = {out_overflow, out_chosen};

endmodule

// ===== test/knapsack_01_dp_solver_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_01_dp_solver_unit_checker
// Watches the item, result and register channels of the knapsack solver,
// predicts each answer run from its own copy of the profit row and keep bits,
// and compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module knapsack_01_dp_solver_unit_checker import kdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [23:0]           s_tdata,   // weight[7:0], profit[23:8]
	input  logic                  s_tlast,   // last_item
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [31:0]           m_tdata,   // chosen_index[4:0], max_profit[25:5]
	input  logic [1:0]            m_tuser,   // chosen_valid[0], overflow[1]
	input  logic                  m_tlast,   // last_result
	output int                    fail_count,
	output int                    pending
);

	// one predicted result item
	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic                chosen;
		logic [PROFIT_W-1:0] profit;
		logic                dropped;
		logic                last;
	} pick_t;

	// solver image: profit row, keep bits, stored weights
	logic [PROFIT_W-1:0]       row_best [0:MAX_CAPACITY_DEF];
	logic [MAX_CAPACITY_DEF:0] took     [0:MAX_ITEMS_DEF-1];
	logic [WEIGHT_W-1:0]       item_wt  [0:MAX_ITEMS_DEF-1];
	int                        n_stored;
	logic                      lost_any;
	logic [CAPACITY_W-1:0]     cap_reg;
	pick_t                     pick_q [$];

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// predict on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin : predict_and_check
		int                      i;
		int                      j;
		int                      k;
		int                      nres;
		logic [WEIGHT_W-1:0]     w;
		logic [ITEM_PROFIT_W-1:0] p;
		logic [PROFIT_W:0]       sum;
		logic [PROFIT_W-1:0]     peak;
		logic                    keep;
		logic                    have;
		pick_t                   held;
		pick_t                   want;
		if (!arst_n) begin
			for (j = 0; j <= MAX_CAPACITY_DEF; j++)
				row_best[j] = '0;
			n_stored   = 0;
			lost_any   = 1'b0;
			cap_reg    = '0;
			fail_count = 0;
			pick_q.delete();
			pending <= 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == CFG_CAPACITY)
				cap_reg = pwdata[CAPACITY_W-1:0];

			// result item against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (pick_q.size() == 0) begin
					$display("%0t: result item with none expected, expected none actual %h/%h/%b",
						$time, m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = pick_q.pop_front();
					check_field("chosen_index", want.index, m_tdata[INDEX_W-1:0]);
					check_field("max_profit", want.profit, m_tdata[INDEX_W +: PROFIT_W]);
					check_field("chosen_valid", want.chosen, m_tuser[0]);
					check_field("overflow", want.dropped, m_tuser[1]);
					check_field("last_result", want.last, m_tlast);
				end
			end

			// input item: row sweep from high capacity down
			if (s_tvalid && s_tready) begin
				w = s_tdata[WEIGHT_W-1:0];
				p = s_tdata[WEIGHT_W +: ITEM_PROFIT_W];
				if (n_stored < MAX_ITEMS_DEF) begin
					item_wt[n_stored] = w;
					for (j = MAX_CAPACITY_DEF; j >= 0; j--) begin
						keep = 1'b0;
						if (j >= w) begin
							sum = {{(PROFIT_W + 1 - ITEM_PROFIT_W){1'b0}}, p}
								+ {1'b0, row_best[j - w]};
							if (sum > {1'b0, {PROFIT_W{1'b1}}})
								sum = {1'b0, {PROFIT_W{1'b1}}};
							if (sum > {1'b0, row_best[j]}) begin
								row_best[j] = sum[PROFIT_W-1:0];
								keep = 1'b1;
							end
						end
						took[n_stored][j] = keep;
					end
					n_stored++;
				end else begin
					lost_any = 1'b1;
				end

				// trace-back on the final item, then a fresh problem
				if (s_tlast) begin
					k    = (cap_reg > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : cap_reg;
					peak = row_best[k];
					nres = 0;
					have = 1'b0;
					held = '0;
					for (i = n_stored - 1; i >= 0 && nres < RES_LIMIT; i--) begin
						if (took[i][k]) begin
							if (have)
								pick_q.push_back(held);
							held.index   = i[INDEX_W-1:0];
							held.chosen  = 1'b1;
							held.profit  = peak;
							held.dropped = lost_any;
							held.last    = 1'b0;
							have = 1'b1;
							nres++;
							k = k - item_wt[i];
						end
					end
					if (!have) begin
						held.index   = '0;
						held.chosen  = 1'b0;
						held.profit  = peak;
						held.dropped = lost_any;
					end
					held.last = 1'b1;
					pick_q.push_back(held);
					for (j = 0; j <= MAX_CAPACITY_DEF; j++)
						row_best[j] = '0;
					n_stored = 0;
					lost_any = 1'b0;
				end
			end
			pending <= pick_q.size();
		end
	end

endmodule

// ===== test/knapsack_01_dp_solver_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_01_dp_solver_unit_test
// Drives knapsack problems into the solver under several capacities and
// idling patterns, including full stores and a long result stall, and gives
// the verdict from the checker's failure count and pending count.
// ----------------------------------------------------------------------------
module knapsack_01_dp_solver_unit_test import kdp_pkg::*;;

	localparam int HOLD_CYCLES    = 4000;
	localparam int SETTLE_CYCLES  = MAX_CAPACITY_DEF + 3 + 2 * MAX_ITEMS_DEF + 8;
	localparam int WATCHDOG_LIMIT = 20000;

	// weight ranges of a generated problem
	typedef enum int {
		WT_ANY,
		WT_LIGHT,
		WT_FIT,
		WT_TINY
	} wt_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // weight[7:0], profit[23:8]
	logic                  s_tlast;   // last_item
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;   // chosen_index[4:0], max_profit[25:5]
	logic [1:0]            m_tuser;   // chosen_valid[0], overflow[1]
	logic                  m_tlast;   // last_result
	int                    fail_count;
	int                    pending;

	int                    src_idle_pct;
	int                    dst_idle_pct;
	int                    items_sent;
	int                    quiet;
	logic                  hold_req;
	logic [CAPACITY_W-1:0] cur_cap;

	knapsack_01_dp_solver_unit DUT (.*);

	knapsack_01_dp_solver_unit_checker checker_i (.*);

	always #5 clk = ~clk;

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		logic hold_taken;
		hold_taken = 1'b0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [ITEM_PROFIT_W-1:0] p,
		input logic l);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p, w};
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering, wait out every expected result and the tail of the work
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAPACITY_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {CFG_CAPACITY, 2'b00};
		pwdata  <= {{(CFG_DATA_W - CAPACITY_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_cap = value;
	endtask

	task automatic send_problem(input int count, input wt_style_t style);
		int                       n;
		logic [WEIGHT_W-1:0]      w;
		logic [ITEM_PROFIT_W-1:0] p;
		for (n = 0; n < count; n++) begin
			unique case (style)
				WT_ANY:   w = WEIGHT_W'($urandom_range(255));
				WT_LIGHT: w = WEIGHT_W'($urandom_range(cur_cap / 4 + 1));
				WT_FIT:   w = WEIGHT_W'($urandom_range(cur_cap));
				default:  w = WEIGHT_W'($urandom_range(7));
			endcase
			p = ($urandom_range(3) == 0) ? ITEM_PROFIT_W'($urandom_range(15))
				: ITEM_PROFIT_W'($urandom);
			send_item(w, p, n == count - 1);
		end
	endtask

	// one idling pattern: an overfull problem first, then mostly short ones
	task automatic run_phase(input int src_pct, input int dst_pct, input int item_goal,
		input logic [CAPACITY_W-1:0] first_cap, input bit with_hold);
		int        prob;
		int        len;
		wt_style_t style;
		settle();
		src_idle_pct = src_pct;
		dst_idle_pct <= dst_pct;
		write_capacity(first_cap);
		prob = 0;
		while (items_sent < item_goal) begin
			if (prob > 2 && $urandom_range(3) == 0) begin
				settle();
				write_capacity(CAPACITY_W'($urandom_range(255)));
			end
			if (prob == 0) begin
				len   = 33 + $urandom_range(3);
				style = WT_TINY;
			end else begin
				len   = ($urandom_range(24) == 0) ? 33 + $urandom_range(3) : 1 + $urandom_range(11);
				style = wt_style_t'($urandom_range(2));
			end
			// long result stall while the sender keeps offering
			if (with_hold && prob == 1) begin
				hold_req <= 1'b1;
				len = 1 + $urandom_range(2);
			end
			send_problem(len, style);
			prob++;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		hold_req     = 1'b0;
		items_sent   = 0;
		cur_cap      = '0;
		src_idle_pct = 14;
		dst_idle_pct = 60;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full capacity: extreme weights and profits, zero-weight items
		write_capacity(8'd255);
		send_item(8'd255, 16'hFFFF, 1'b0);
		send_item(8'd0, 16'h0000, 1'b0);
		send_item(8'd0, 16'h0001, 1'b0);
		send_item(8'd1, 16'hFFFF, 1'b0);
		send_item(8'd128, 16'hAAAA, 1'b0);
		send_item(8'd127, 16'h5555, 1'b1);
		// nothing chosen: zero profit
		send_item(8'd10, 16'h0000, 1'b1);

		// zero capacity: only zero-weight items fit
		settle();
		write_capacity(8'd0);
		send_item(8'd0, 16'd300, 1'b0);
		send_item(8'd1, 16'hFFFF, 1'b0);
		send_item(8'd0, 16'h0000, 1'b1);
		// nothing chosen: too heavy
		send_item(8'd200, 16'd5000, 1'b1);

		// capacity one: ties are not taken
		settle();
		write_capacity(8'd1);
		send_item(8'd1, 16'd7, 1'b0);
		send_item(8'd1, 16'd9, 1'b0);
		send_item(8'd0, 16'd2, 1'b1);
		send_item(8'd1, 16'd9, 1'b0);
		send_item(8'd1, 16'd9, 1'b1);

		run_phase(14, 60, 150, 8'd255, 1'b0);
		run_phase(60, 14, 290, CAPACITY_W'($urandom_range(255)), 1'b1);
		run_phase(0, 0, 420, 8'd0, 1'b0);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
